[rtl/core/cubic_bezier_curvature_macros.svh]
// ----------------------------------------------------------------------------
// cubic_bezier_curvature_macros.svh
// Assertion shorthands for the Bezier curvature block.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_CURVATURE_MACROS_SVH
`define CUBIC_BEZIER_CURVATURE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared widths, register indexes and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

    // t is handled internally as Q0.16
    localparam int TQ_BITS    = 16;
    localparam int GUARD_BITS = 6;
    // datapath sized for the widest supported coordinate
    localparam int MAX_CB     = 21;

    localparam int DIFF_W = MAX_CB + 3;
    localparam int D1_W   = 30;
    localparam int D2_W   = 32;
    localparam int RND1   = 2 * TQ_BITS - GUARD_BITS;
    localparam int RND2   = TQ_BITS - GUARD_BITS;

    localparam int CSQ_W  = 128;
    localparam int DSQ_W  = 64;
    localparam int DMAG_W = DSQ_W / 2;
    localparam int CMAG_W = CSQ_W / 2;
    localparam int DEN_W  = 96;
    localparam int NUM_W  = 128;
    localparam int CURV_W = 32;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_START_POINT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_CONTROL  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_CONTROL = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END_POINT      = 2'd3;

    typedef struct packed {
        logic [2:0][D1_W-1:0] d1;
        logic [2:0][D2_W-1:0] d2;
    } t_deriv;

    typedef struct packed {
        logic [CSQ_W-1:0] csq;
        logic [DSQ_W-1:0] dsq;
        logic             deg;
    } t_cross;

    typedef struct packed {
        logic [CSQ_W-1:0] csq;
        logic             deg;
    } t_rootd_side;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [CSQ_W-1:0] csq;
        logic             deg;
    } t_cube;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic             deg;
    } t_rootc_side;

    typedef struct packed {
        logic [CURV_W-1:0] curv;
        logic              deg;
        logic              sat;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/cubic_bezier_curvature.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_curvature
// Curvature of a 3D cubic Bezier curve at parameter t, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Load the four control points through the write port (index 0..3 =
//   start, first control, second control, end; x,y,z Q10.10 packed from
//   bit 0). Then stream t values (Q0.16, 65536 = one, larger is clamped)
//   on the slave side; one result per t comes out on the master side in
//   the same order: curvature Q16.16 in tdata, degenerate/saturated flags
//   in tuser.
// Stages: 5 derivative, 5 cross/square, 32 root of |B'|^2, 3 cube, 64 root
//   of |BxB|^2, 33 divide, 1 output register.
// Throughput: one transfer per cycle while the skid entry is free; every
//   stage is a single register step, the 64-stage root of the 128-bit
//   cross-product norm sets depth.
// Reset clears control points to zero and empties the pipeline.
// Stall: a two-entry output (register plus skid) lets the pipeline keep
//   taking input while a result waits; when both are full the whole
//   pipeline freezes and tready drops, nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_curvature #(
    parameter int COORD_BITS  = 20,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [cbc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [3*COORD_BITS-1:0]             i_cfg_data,
    // input stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: param_t, zero padded to bytes
    input  wire logic [((T_FRAC_BITS+8)/8)*8-1:0]    i_s_tdata,
    // output stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata: curvature
    output logic [cbc_pkg::CURV_W-1:0]               o_m_tdata,
    // tuser: [0] degenerate, [1] saturated
    output logic [1:0]                               o_m_tuser
);

`include "cubic_bezier_curvature_macros.svh"

    localparam int PW = 3 * COORD_BITS;

    // control points
    logic [PW-1:0] r_p0, r_p1, r_p2, r_p3;

    // global advance: pipeline moves whenever the skid entry is free
    logic w_en;

    logic                    w_dv_v;
    cbc_pkg::t_deriv         w_deriv;
    logic                    w_cr_v;
    cbc_pkg::t_cross         w_cross;
    cbc_pkg::t_rootd_side    w_rd_in;
    logic                    w_rd_v;
    logic [cbc_pkg::DMAG_W-1:0] w_dmag;
    cbc_pkg::t_rootd_side    w_rd_out;
    logic                    w_cb_v;
    cbc_pkg::t_cube          w_cube;
    cbc_pkg::t_rootc_side    w_rc_in;
    logic                    w_rc_v;
    logic [cbc_pkg::CMAG_W-1:0] w_cmag;
    cbc_pkg::t_rootc_side    w_rc_out;
    logic                    w_res_v;
    cbc_pkg::t_result        w_res;

    // output register and skid entry
    logic             r_out_v;
    cbc_pkg::t_result r_out;
    logic             r_skid_v;
    cbc_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cbc_pkg::REG_START_POINT:    r_p0 <= i_cfg_data;
                cbc_pkg::REG_FIRST_CONTROL:  r_p1 <= i_cfg_data;
                cbc_pkg::REG_SECOND_CONTROL: r_p2 <= i_cfg_data;
                cbc_pkg::REG_END_POINT:      r_p3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    // stage group 1: derivatives
    cbc_deriv #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_deriv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_t     (i_s_tdata[T_FRAC_BITS:0]),
        .i_p0    (r_p0),
        .i_p1    (r_p1),
        .i_p2    (r_p2),
        .i_p3    (r_p3),
        .o_valid (w_dv_v),
        .o_deriv (w_deriv)
    );

    // stage group 2: cross product and squared norms
    cbc_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_v),
        .i_deriv (w_deriv),
        .o_valid (w_cr_v),
        .o_cross (w_cross)
    );

    assign w_rd_in.csq = w_cross.csq;
    assign w_rd_in.deg = w_cross.deg;

    // |B'|
    cbc_sqrt #(
        .ROOT_W (cbc_pkg::DMAG_W),
        .SIDE_W ($bits(cbc_pkg::t_rootd_side))
    ) u_root_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cr_v),
        .i_rad   (w_cross.dsq),
        .i_side  (w_rd_in),
        .o_valid (w_rd_v),
        .o_root  (w_dmag),
        .o_side  (w_rd_out)
    );

    // |B'|^3
    cbc_cube u_cube (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rd_v),
        .i_dmag  (w_dmag),
        .i_side  (w_rd_out),
        .o_valid (w_cb_v),
        .o_cube  (w_cube)
    );

    assign w_rc_in.den = w_cube.den;
    assign w_rc_in.deg = w_cube.deg;

    // |B' x B''|
    cbc_sqrt #(
        .ROOT_W (cbc_pkg::CMAG_W),
        .SIDE_W ($bits(cbc_pkg::t_rootc_side))
    ) u_root_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cb_v),
        .i_rad   (w_cube.csq),
        .i_side  (w_rc_in),
        .o_valid (w_rc_v),
        .o_root  (w_cmag),
        .o_side  (w_rc_out)
    );

    // quotient, overflow and degenerate flags
    cbc_quot #(
        .COORD_BITS (COORD_BITS)
    ) u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rc_v),
        .i_cmag  (w_cmag),
        .i_side  (w_rc_out),
        .o_valid (w_res_v),
        .o_res   (w_res)
    );

    // Output register with one skid entry. A result arriving while the
    // output is held goes to the skid entry, which freezes the pipeline
    // until the receiver takes the held transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_tready) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (w_res_v && r_out_v && !i_m_tready) begin
            r_skid   <= w_res;
            r_skid_v <= 1'b1;
        end else if (!r_out_v || i_m_tready) begin
            r_out_v <= w_res_v;
            r_out   <= w_res;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = r_out.curv;
    assign o_m_tuser[0] = r_out.deg;
    assign o_m_tuser[1] = r_out.sat;

    `CBC_ASSERT_NOW(a_deg_max, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == '1, "degenerate result without maximum curvature")
    `CBC_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, o_m_tvalid, !(o_m_tuser[0] && o_m_tuser[1]), "degenerate and saturated both set")
    `CBC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid entry full while output register empty")
    `CBC_ASSERT_NEXT(a_skid_hold, i_clk, i_rst_n, r_skid_v && !i_m_tready, r_skid_v && $stable(r_skid), "skid entry lost while receiver stalled")

endmodule

`default_nettype wire

[rtl/core/cbc_deriv.sv]
// ----------------------------------------------------------------------------
// cbc_deriv
// Five-stage pipeline forming the rounded first and second derivatives.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_deriv #(
    parameter int COORD_BITS  = 20,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [T_FRAC_BITS:0]      i_t,
    input  wire logic [3*COORD_BITS-1:0]   i_p0,
    input  wire logic [3*COORD_BITS-1:0]   i_p1,
    input  wire logic [3*COORD_BITS-1:0]   i_p2,
    input  wire logic [3*COORD_BITS-1:0]   i_p3,
    output logic                           o_valid,
    output cbc_pkg::t_deriv                o_deriv
);

    localparam int TW   = T_FRAC_BITS + 1;
    localparam int TQB  = cbc_pkg::TQ_BITS;
    localparam int QW   = TQB + 1;
    localparam int DW   = cbc_pkg::DIFF_W;
    localparam int PA_W = QW + 1 + DW;
    localparam int V2W  = PA_W + 4;
    localparam int UUW  = 2 * QW;
    localparam int M_W  = UUW + 1 + DW;
    localparam int V1W  = M_W + 4;
    localparam int D1W  = cbc_pkg::D1_W;
    localparam int D2W  = cbc_pkg::D2_W;
    localparam int R1   = cbc_pkg::RND1;
    localparam int R2   = cbc_pkg::RND2;

    localparam logic [TW-1:0]  T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0]  Q_ONE = {1'b1, {TQB{1'b0}}};
    localparam logic [V1W-1:0] HALF1 = V1W'(1) << (R1 - 1);
    localparam logic [V2W-1:0] HALF2 = V2W'(1) << (R2 - 1);

    // round half away from zero
    function automatic logic [D1W-1:0] rnd1(input logic signed [V1W-1:0] v);
        logic [V1W-1:0] mag;
        logic [V1W-1:0] q;
        mag = v[V1W-1] ? V1W'(-v) : V1W'(v);
        q   = (mag + HALF1) >> R1;
        return v[V1W-1] ? D1W'(-q) : D1W'(q);
    endfunction

    function automatic logic [D2W-1:0] rnd2(input logic signed [V2W-1:0] v);
        logic [V2W-1:0] mag;
        logic [V2W-1:0] q;
        mag = v[V2W-1] ? V2W'(-v) : V2W'(v);
        q   = (mag + HALF2) >> R2;
        return v[V2W-1] ? D2W'(-q) : D2W'(q);
    endfunction

    logic [4:0]    r_vld;
    logic [TW-1:0] w_tcl;
    logic [QW-1:0] w_tq;

    logic [QW-1:0]  r_tq;
    logic [QW-1:0]  r_u;
    logic [UUW-1:0] r_uu;
    logic [UUW-1:0] r_tu2;
    logic [UUW-1:0] r_tt;
    logic [UUW-1:0] w_tu;

    logic signed [QW:0]  w_us;
    logic signed [QW:0]  w_ts;
    logic signed [UUW:0] w_uus;
    logic signed [UUW:0] w_tus;
    logic signed [UUW:0] w_tts;

    logic signed [DW-1:0]   w_a  [3];
    logic signed [DW-1:0]   w_b  [3];
    logic signed [DW-1:0]   w_c  [3];
    logic signed [DW-1:0]   w_e  [3];
    logic signed [DW-1:0]   w_f  [3];
    logic signed [PA_W-1:0] r_pa [3];
    logic signed [PA_W-1:0] r_pb [3];
    logic signed [M_W-1:0]  r_m1 [3];
    logic signed [M_W-1:0]  r_m2 [3];
    logic signed [M_W-1:0]  r_m3 [3];
    logic signed [V2W-1:0]  r_v2 [3];
    logic signed [V2W-1:0]  r_v2d[3];
    logic signed [V1W-1:0]  r_v1 [3];

    cbc_pkg::t_deriv r_out;

    // t clamp and conversion to Q0.16
    assign w_tcl = (i_t > T_ONE) ? T_ONE : i_t;

    if (T_FRAC_BITS <= TQB) begin : g_tup
        assign w_tq = QW'(w_tcl) << (TQB - T_FRAC_BITS);
    end else begin : g_tdn
        localparam int SH = T_FRAC_BITS - TQB;
        localparam logic [TW-1:0] THALF = TW'(1) << (SH - 1);
        assign w_tq = QW'((w_tcl + THALF) >> SH);
    end

    assign w_tu  = r_tq * r_u;
    assign w_us  = $signed({1'b0, r_u});
    assign w_ts  = $signed({1'b0, r_tq});
    assign w_uus = $signed({1'b0, r_uu});
    assign w_tus = $signed({1'b0, r_tu2});
    assign w_tts = $signed({1'b0, r_tt});

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic signed [DW-1:0]   w_c0, w_c1, w_c2, w_c3;
        logic signed [PA_W:0]   w_s2;
        logic signed [M_W+1:0]  w_s1;
        assign w_c0 = DW'($signed(i_p0[i*COORD_BITS +: COORD_BITS]));
        assign w_c1 = DW'($signed(i_p1[i*COORD_BITS +: COORD_BITS]));
        assign w_c2 = DW'($signed(i_p2[i*COORD_BITS +: COORD_BITS]));
        assign w_c3 = DW'($signed(i_p3[i*COORD_BITS +: COORD_BITS]));
        assign w_a[i] = w_c1 - w_c0;
        assign w_b[i] = w_c2 - w_c1;
        assign w_c[i] = w_c3 - w_c2;
        assign w_e[i] = w_b[i] - w_a[i];
        assign w_f[i] = w_c[i] - w_b[i];
        assign w_s2 = (PA_W+1)'(r_pa[i]) + (PA_W+1)'(r_pb[i]);
        assign w_s1 = (M_W+2)'(r_m1[i]) + (M_W+2)'(r_m2[i]) + (M_W+2)'(r_m3[i]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[i]  <= w_us * w_e[i];
                r_pb[i]  <= w_ts * w_f[i];
                r_m1[i]  <= w_uus * w_a[i];
                r_m2[i]  <= w_tus * w_b[i];
                r_m3[i]  <= w_tts * w_c[i];
                r_v2[i]  <= (V2W'(w_s2) <<< 2) + (V2W'(w_s2) <<< 1);
                r_v1[i]  <= (V1W'(w_s1) <<< 1) + V1W'(w_s1);
                r_v2d[i] <= r_v2[i];
                r_out.d1[i] <= rnd1(r_v1[i]);
                r_out.d2[i] <= rnd2(r_v2d[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tq  <= w_tq;
            r_u   <= Q_ONE - w_tq;
            r_uu  <= r_u * r_u;
            r_tu2 <= w_tu << 1;
            r_tt  <= r_tq * r_tq;
        end
    end

    assign o_valid = r_vld[4];
    assign o_deriv = r_out;

endmodule

`default_nettype wire

[rtl/core/cbc_cross.sv]
// ----------------------------------------------------------------------------
// cbc_cross
// Cross product, squared magnitudes of B' x B'' and of B'.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_cross (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_valid,
    input  cbc_pkg::t_deriv i_deriv,
    output logic           o_valid,
    output cbc_pkg::t_cross o_cross
);

    localparam int D1W  = cbc_pkg::D1_W;
    localparam int D2W  = cbc_pkg::D2_W;
    localparam int PR_W = D1W + D2W;
    localparam int NN_W = 2 * D1W;
    localparam int MW   = PR_W;
    localparam int HW   = MW - 32;
    localparam int CW   = cbc_pkg::CSQ_W;
    localparam int SW   = cbc_pkg::DSQ_W;

    logic [4:0] r_vld;
    logic [4:0] r_deg;

    logic signed [D1W-1:0]  w_d1 [3];
    logic signed [D2W-1:0]  w_d2 [3];
    logic signed [PR_W-1:0] r_pr [6];
    logic signed [NN_W-1:0] r_nn [3];
    logic [MW-1:0]          r_mag[3];
    logic [2*HW-1:0]        r_hh [3];
    logic [MW-1:0]          r_hl [3];
    logic [63:0]            r_ll [3];
    logic [CW-1:0]          r_sq [3];
    logic [CW-1:0]          r_csq;
    logic [SW-1:0]          r_dsq [4];

    for (genvar i = 0; i < 3; i++) begin : g_ax
        logic signed [PR_W:0] w_cr;
        assign w_d1[i] = $signed(i_deriv.d1[i]);
        assign w_d2[i] = $signed(i_deriv.d2[i]);
        assign w_cr = (PR_W+1)'(r_pr[2*i]) - (PR_W+1)'(r_pr[2*i+1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nn[i]  <= w_d1[i] * w_d1[i];
                r_mag[i] <= w_cr[PR_W] ? MW'(-w_cr) : MW'(w_cr);
                r_hh[i]  <= r_mag[i][MW-1:32] * r_mag[i][MW-1:32];
                r_hl[i]  <= r_mag[i][MW-1:32] * r_mag[i][31:0];
                r_ll[i]  <= r_mag[i][31:0] * r_mag[i][31:0];
                r_sq[i]  <= (CW'(r_hh[i]) << 64) + (CW'(r_hl[i]) << 33) + CW'(r_ll[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // dsq and the zero flag are delayed to line up with csq at stage five
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // x = y*z' - z*y', y = z*x' - x*z', z = x*y' - y*x'
            r_pr[0]  <= w_d1[1] * w_d2[2];
            r_pr[1]  <= w_d1[2] * w_d2[1];
            r_pr[2]  <= w_d1[2] * w_d2[0];
            r_pr[3]  <= w_d1[0] * w_d2[2];
            r_pr[4]  <= w_d1[0] * w_d2[1];
            r_pr[5]  <= w_d1[1] * w_d2[0];
            r_deg    <= {r_deg[3:0], (w_d1[0] == '0) && (w_d1[1] == '0) && (w_d1[2] == '0)};
            r_dsq[0] <= SW'($unsigned(r_nn[0])) + SW'($unsigned(r_nn[1]))
                        + SW'($unsigned(r_nn[2]));
            r_dsq[1] <= r_dsq[0];
            r_dsq[2] <= r_dsq[1];
            r_dsq[3] <= r_dsq[2];
            r_csq    <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_valid     = r_vld[4];
    assign o_cross.csq = r_csq;
    assign o_cross.dsq = r_dsq[3];
    assign o_cross.deg = r_deg[4];

endmodule

`default_nettype wire

[rtl/core/cbc_sqrt.sv]
// ----------------------------------------------------------------------------
// cbc_sqrt
// Pipelined floor square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_sqrt #(
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [2*ROOT_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_valid,
    output logic [ROOT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int RW = 2 * ROOT_W + 2;

    logic [ROOT_W-1:0] r_vld;
    logic [RW-1:0]     r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
        localparam int B = ROOT_W - 1 - k;
        logic [RW-1:0]     w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [SIDE_W-1:0] w_side;
        logic [RW-1:0]     n_test;

        if (k == 0) begin : g_first
            assign w_rem  = RW'(i_rad);
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        // (r + 2^B)^2 - r^2, lower root bits are still zero
        assign n_test = (RW'(w_root) << (B + 1)) | (RW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side;
                if (w_rem >= n_test) begin
                    r_rem[k]  <= w_rem - n_test;
                    r_root[k] <= w_root | (ROOT_W'(1) << B);
                end else begin
                    r_rem[k]  <= w_rem;
                    r_root[k] <= w_root;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ROOT_W-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/core/cbc_cube.sv]
// ----------------------------------------------------------------------------
// cbc_cube
// Three-stage |B'|^3 using 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_cube (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [cbc_pkg::DMAG_W-1:0]  i_dmag,
    input  cbc_pkg::t_rootd_side             i_side,
    output logic                             o_valid,
    output cbc_pkg::t_cube                   o_cube
);

    localparam int MW = cbc_pkg::DMAG_W;
    localparam int DW = cbc_pkg::DEN_W;

    logic [2:0]        r_vld;
    logic [2*MW-1:0]   r_sq;
    logic [MW-1:0]     r_dm;
    logic [2*MW-1:0]   r_ph;
    logic [2*MW-1:0]   r_pl;
    logic [DW-1:0]     r_den;
    cbc_pkg::t_rootd_side r_side [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq      <= i_dmag * i_dmag;
            r_dm      <= i_dmag;
            r_ph      <= r_sq[2*MW-1:MW] * r_dm;
            r_pl      <= r_sq[MW-1:0] * r_dm;
            r_den     <= (DW'(r_ph) << MW) + DW'(r_pl);
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
        end
    end

    assign o_valid     = r_vld[2];
    assign o_cube.den  = r_den;
    assign o_cube.csq  = r_side[2].csq;
    assign o_cube.deg  = r_side[2].deg;

endmodule

`default_nettype wire

[rtl/core/cbc_quot.sv]
// ----------------------------------------------------------------------------
// cbc_quot
// Overflow check and 32-stage restoring divide |cross| / |B'|^3.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_quot #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [cbc_pkg::CMAG_W-1:0]  i_cmag,
    input  cbc_pkg::t_rootc_side             i_side,
    output logic                             o_valid,
    output cbc_pkg::t_result                 o_res
);

    localparam int NW = cbc_pkg::NUM_W;
    localparam int DW = cbc_pkg::DEN_W;
    localparam int QB = cbc_pkg::CURV_W;
    localparam int SH = COORD_BITS / 2 + cbc_pkg::GUARD_BITS + 16;

    logic [QB:0]   r_vld;
    logic [NW-1:0] w_num;
    logic [NW-1:0] w_lim;
    logic [NW-1:0] r_num0;
    logic [DW-1:0] r_den0;
    logic          r_sat0;
    logic          r_deg0;

    logic [NW-1:0] r_num [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB];
    logic [QB-1:0] r_sat;
    logic [QB-1:0] r_deg;

    assign w_num = NW'(i_cmag) << SH;
    assign w_lim = NW'(i_side.den) << QB;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num0 <= w_num;
            r_den0 <= i_side.den;
            r_sat0 <= (w_num >= w_lim);
            r_deg0 <= i_side.deg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stg
        localparam int B = QB - 1 - k;
        logic [NW-1:0] w_n;
        logic [DW-1:0] w_d;
        logic [QB-1:0] w_q;
        logic          w_s;
        logic          w_g;
        logic [NW-1:0] n_part;

        if (k == 0) begin : g_first
            assign w_n = r_num0;
            assign w_d = r_den0;
            assign w_q = '0;
            assign w_s = r_sat0;
            assign w_g = r_deg0;
        end else begin : g_next
            assign w_n = r_num[k-1];
            assign w_d = r_den[k-1];
            assign w_q = r_q[k-1];
            assign w_s = r_sat[k-1];
            assign w_g = r_deg[k-1];
        end

        assign n_part = NW'(w_d) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= w_d;
                r_sat[k] <= w_s;
                r_deg[k] <= w_g;
                if (w_n >= n_part) begin
                    r_num[k] <= w_n - n_part;
                    r_q[k]   <= w_q | (QB'(1) << B);
                end else begin
                    r_num[k] <= w_n;
                    r_q[k]   <= w_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QB-1:0], i_valid};
        end
    end

    // zero B' also trips the overflow compare; report it as degenerate only
    assign o_valid    = r_vld[QB];
    assign o_res.curv = (r_deg[QB-1] || r_sat[QB-1]) ? '1 : r_q[QB-1];
    assign o_res.deg  = r_deg[QB-1];
    assign o_res.sat  = r_sat[QB-1] && !r_deg[QB-1];

endmodule

`default_nettype wire
